[rtl/cnms_pkg.sv]
// Shared constants, types and codes for the non-maximum suppression block.
// Used by the channel interfaces and the top level.
`default_nettype none
package cnms_pkg;

   localparam int MAX_LINE  = 2048;
   localparam int MAG_BITS  = 16;
   localparam int ANG_BITS  = 10;
   localparam int COL_BITS  = $clog2(MAX_LINE);
   localparam int ROW_BITS  = 12;
   localparam int CFG_BITS  = 12;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
   localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);
   localparam logic [CFG_BITS-1:0] DIM_MIN      = CFG_BITS'(3);

   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH  = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT = CSR_IDX_BITS'(1);

   // direction thresholds in half degrees
   localparam logic [ANG_BITS-1:0] ANG_FOLD    = ANG_BITS'(360);
   localparam logic [ANG_BITS-1:0] ANG_45_LO   = ANG_BITS'(45);
   localparam logic [ANG_BITS-1:0] ANG_90_LO   = ANG_BITS'(135);
   localparam logic [ANG_BITS-1:0] ANG_135_LO  = ANG_BITS'(225);
   localparam logic [ANG_BITS-1:0] ANG_135_END = ANG_BITS'(315);

   typedef enum logic [1:0] {
      DIR_0,
      DIR_45,
      DIR_90,
      DIR_135
   } dir_type;

   typedef struct packed {
      logic [MAG_BITS-1:0] mag_prev2;
      logic [MAG_BITS-1:0] mag_prev;
      logic [ANG_BITS-1:0] ang_prev;
   } line_entry_type;

   localparam int LINE_BITS = $bits(line_entry_type);

endpackage
`default_nettype wire

[rtl/cnms_req_if.sv]
// Request channel: one gradient pixel per transfer, valid/ready handshake.
// Depends on cnms_pkg for field widths.
`default_nettype none
interface cnms_req_if;
   import cnms_pkg::*;
   logic                valid;
   logic                ready;
   logic [MAG_BITS-1:0] grad_mag;
   logic [ANG_BITS-1:0] angle_half_deg;
   logic                frame_start;

   modport source (output valid, grad_mag, angle_half_deg, frame_start, input ready);
   modport sink   (input valid, grad_mag, angle_half_deg, frame_start, output ready);
endinterface
`default_nettype wire

[rtl/cnms_rsp_if.sv]
// Response channel: one interior pixel with its coordinates per transfer.
// Depends on cnms_pkg for field widths.
`default_nettype none
interface cnms_rsp_if;
   import cnms_pkg::*;
   logic                valid;
   logic                ready;
   logic [ROW_BITS-1:0] out_row;
   logic [COL_BITS-1:0] out_col;
   logic [MAG_BITS-1:0] kept_mag;

   modport source (output valid, out_row, out_col, kept_mag, input ready);
   modport sink   (input valid, out_row, out_col, kept_mag, output ready);
endinterface
`default_nettype wire

[rtl/cnms_csr_if.sv]
// Register write channel: register index and write data, valid/ready handshake.
// Depends on cnms_pkg for field widths.
`default_nettype none
interface cnms_csr_if;
   import cnms_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [CFG_BITS-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/cnms_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cnms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

[rtl/canny_non_max_suppression_top.sv]
// Canny non-maximum suppression over a 3x3 window, raster-order pixel stream.
// Depends on cnms_pkg, the three channel interfaces and cnms_ram.
//
//   channel  dir  handshake      payload
//   req_ch   in   valid/ready    grad_mag, angle_half_deg, frame_start
//   rsp_ch   out  valid/ready    out_row, out_col, kept_mag
//   csr_ch   in   valid/ready    index, data (image_width, image_height)
//
// One pixel per cycle sustained unless the response stalls. A pixel reads
// the line RAM on acceptance; the resolve stage takes the RAM data, writes
// the entry back and registers the result for the response. Reset is
// synchronous and needs no clearing pass. A stalled response holds the
// resolve stage and, behind it, further requests; csr_ch is always ready.
`default_nettype none
module canny_non_max_suppression_top (
   input wire logic  clock,
   input wire logic  reset,
   cnms_req_if.sink   req_ch,
   cnms_rsp_if.source rsp_ch,
   cnms_csr_if.sink   csr_ch
);
   import cnms_pkg::*;

   logic [CFG_BITS-1:0] eff_width_ff, eff_height_ff;
   logic [COL_BITS-1:0] col_count_ff, col_count_in;
   logic [ROW_BITS-1:0] row_count_ff, row_count_in;

   logic                s1_valid_ff;
   logic [MAG_BITS-1:0] s1_mag_ff;
   logic [ANG_BITS-1:0] s1_ang_ff;
   logic [COL_BITS-1:0] s1_col_ff;
   logic [ROW_BITS-1:0] s1_row_ff;

   logic                fwd_valid_ff, fwd_valid_in;
   line_entry_type      fwd_data_ff;

   logic [MAG_BITS-1:0] win_ff [6];
   logic [ANG_BITS-1:0] centre_ang_ff;

   logic                rsp_valid_ff;
   logic [ROW_BITS-1:0] out_row_ff;
   logic [COL_BITS-1:0] out_col_ff;
   logic [MAG_BITS-1:0] kept_mag_ff;

   logic                accept, advance, produce, out_free;
   logic [COL_BITS-1:0] cur_col;
   logic [ROW_BITS-1:0] cur_row;
   logic [COL_BITS:0]   col_next;
   logic [ROW_BITS:0]   row_next;
   logic [LINE_BITS-1:0] ram_rd_data;
   line_entry_type      rd_entry, wr_entry;
   logic [ANG_BITS-1:0] ang_fold;
   dir_type             dir;
   logic [MAG_BITS-1:0] top, mid, bot, n1, n2, nmax, kept;
   logic [CFG_BITS:0]   csr_wide;

   // configuration
   assign csr_ch.ready = 1'b1;
   assign csr_wide     = {1'b0, csr_ch.data};

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_width_ff  <= WIDTH_RESET;
         eff_height_ff <= HEIGHT_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_IMAGE_WIDTH: begin
               if (csr_ch.data < DIM_MIN) begin
                  eff_width_ff <= DIM_MIN;
               end else if (csr_wide > (CFG_BITS+1)'(MAX_LINE)) begin
                  eff_width_ff <= CFG_BITS'(MAX_LINE);
               end else begin
                  eff_width_ff <= csr_ch.data;
               end
            end
            CSR_IMAGE_HEIGHT: begin
               eff_height_ff <= (csr_ch.data < DIM_MIN) ? DIM_MIN : csr_ch.data;
            end
            default: begin
            end
         endcase
      end
   end

   // handshake
   assign produce  = (s1_row_ff >= ROW_BITS'(2)) && (s1_col_ff >= COL_BITS'(2));
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign advance  = s1_valid_ff && (!produce || out_free);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign accept   = req_ch.valid && req_ch.ready;

   // position of the incoming pixel and counter advance
   assign cur_col  = req_ch.frame_start ? '0 : col_count_ff;
   assign cur_row  = req_ch.frame_start ? '0 : row_count_ff;
   assign col_next = {1'b0, cur_col} + (COL_BITS+1)'(1);
   assign row_next = {1'b0, cur_row} + (ROW_BITS+1)'(1);

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (accept) begin
         if (col_next >= (COL_BITS+1)'(eff_width_ff)) begin
            col_count_in = '0;
            row_count_in = (row_next >= (ROW_BITS+1)'(eff_height_ff)) ? '0
                                                                       : row_next[ROW_BITS-1:0];
         end else begin
            col_count_in = col_next[COL_BITS-1:0];
            row_count_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   // line RAM: read on acceptance, write back on resolve
   cnms_ram #(
      .WIDTH (LINE_BITS),
      .DEPTH (MAX_LINE)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (s1_col_ff),
      .wr_data (wr_entry),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (ram_rd_data)
   );

   // forward a write-back that hits the entry being read in the same cycle
   assign fwd_valid_in = advance && (s1_col_ff == cur_col);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff  <= 1'b1;
            fwd_valid_ff <= fwd_valid_in;
         end else if (advance) begin
            s1_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mag_ff   <= req_ch.grad_mag;
         s1_ang_ff   <= req_ch.angle_half_deg;
         s1_col_ff   <= cur_col;
         s1_row_ff   <= cur_row;
         fwd_data_ff <= wr_entry;
      end
   end

   // resolve stage
   assign rd_entry = fwd_valid_ff ? fwd_data_ff : line_entry_type'(ram_rd_data);
   assign top = rd_entry.mag_prev2;
   assign mid = rd_entry.mag_prev;
   assign bot = s1_mag_ff;

   always_comb begin
      wr_entry.mag_prev2 = mid;
      wr_entry.mag_prev  = s1_mag_ff;
      wr_entry.ang_prev  = s1_ang_ff;
   end

   assign ang_fold = (centre_ang_ff > ANG_FOLD) ? (centre_ang_ff - ANG_FOLD) : centre_ang_ff;

   always_comb begin
      if (ang_fold inside {[ANG_45_LO:ANG_90_LO-1]}) begin
         dir = DIR_45;
      end else if (ang_fold inside {[ANG_90_LO:ANG_135_LO-1]}) begin
         dir = DIR_90;
      end else if (ang_fold inside {[ANG_135_LO:ANG_135_END-1]}) begin
         dir = DIR_135;
      end else begin
         dir = DIR_0;
      end
   end

   always_comb begin
      case (dir)
         DIR_45: begin
            n1 = top;
            n2 = win_ff[4];
         end
         DIR_90: begin
            n1 = win_ff[1];
            n2 = win_ff[5];
         end
         DIR_135: begin
            n1 = win_ff[0];
            n2 = bot;
         end
         default: begin
            n1 = mid;
            n2 = win_ff[2];
         end
      endcase
   end

   assign nmax = (n1 > n2) ? n1 : n2;
   assign kept = (win_ff[3] >= nmax) ? win_ff[3] : '0;

   // shift the window one column left
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
         centre_ang_ff <= '0;
      end else if (advance) begin
         win_ff[0]     <= win_ff[1];
         win_ff[1]     <= top;
         win_ff[2]     <= win_ff[3];
         win_ff[3]     <= mid;
         win_ff[4]     <= win_ff[5];
         win_ff[5]     <= bot;
         centre_ang_ff <= rd_entry.ang_prev;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && produce) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && produce) begin
         out_row_ff  <= s1_row_ff - ROW_BITS'(1);
         out_col_ff  <= s1_col_ff - COL_BITS'(1);
         kept_mag_ff <= kept;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_row  = out_row_ff;
   assign rsp_ch.out_col  = out_col_ff;
   assign rsp_ch.kept_mag = kept_mag_ff;

endmodule
`default_nettype wire
